// File: rtl/core/rle_pkg.sv
// ----------------------------------------------------------------------------
// Run/literal encoder package
// Shared sizes, header constants, item types and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int MAX_PACKET = 127;
    localparam int LANE_BYTES = 8;
    localparam int CNT_W      = $clog2(MAX_PACKET + 1);
    localparam int ADDR_W     = $clog2(MAX_PACKET);
    localparam int LANE_IDX_W = $clog2(LANE_BYTES);
    localparam int BC_W       = 4;
    localparam int WORD_W     = 64;

    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] LIT_FLAG = 8'h00;
    localparam logic [7:0] LEN_MASK = 8'h7f;

    typedef struct packed {
        logic       is_final;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic              stream_end;
        logic              last_for_item;
        logic [BC_W-1:0]   byte_count;
        logic [WORD_W-1:0] packed_bytes;
    } t_out_item;

    typedef enum logic [2:0] {
        RUN_HOLD,
        RUN_NEW,
        RUN_INC,
        RUN_DEC,
        RUN_START2,
        RUN_ZERO,
        RUN_CLEAR
    } t_run_op;

    typedef enum logic [2:0] {
        LIT_HOLD,
        LIT_ADD_BYTE,
        LIT_ADD_RUN,
        LIT_DEC,
        LIT_CLEAR
    } t_lit_op;

    typedef enum logic [1:0] {
        RD_HOLD,
        RD_LAST,
        RD_FIRST,
        RD_NEXT
    } t_rd_op;

    typedef enum logic [2:0] {
        PUT_NONE,
        PUT_LIT_HDR,
        PUT_RUN_HDR,
        PUT_RUN_VAL,
        PUT_MEM
    } t_put_sel;

    typedef struct packed {
        logic     load;
        t_run_op  run_op;
        t_lit_op  lit_op;
        t_rd_op   rd_op;
        t_put_sel put;
        logic     flush;
    } t_cmd;

    typedef struct packed {
        logic item_fin;
        logic lit_zero;
        logic run_zero;
        logic run_one;
        logic run_gt2;
        logic rv_eq_b;
        logic last_eq_b;
        logic run_inc_full;
        logic lit_inc_full;
        logic left_one;
        logic put_ready;
        logic slot_free;
        logic acc_empty;
    } t_status;

endpackage

// File: rtl/core/rle_run_literal_encoder.sv
// ----------------------------------------------------------------------------
// Run/literal byte encoder
// Encodes a raw byte stream into run packets and literal packets with 7-bit
// lengths and delivers the compressed bytes eight to a word.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
//
// An item that emits no byte and does not end the stream may first move a short
// run of one or two bytes into the literal store. Packet bytes leave the literal
// store through its single read port one a cycle while the packer can take them;
// a full literal flush is 128 bytes. An item that ends the stream may make a
// second flush decision, after a short run first moves into the literal store.
// Reset is synchronous and clears the counters, the run value, the packer and
// the output valid; the literal store is not cleared, and no value read from it
// is used before it is written.
// A held output word stalls the sequencer only when the packer needs to
// hand over another word.
// ----------------------------------------------------------------------------
module rle_run_literal_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rle_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rle_pkg::t_out_item o_out_data
);
    import rle_pkg::*;

    t_cmd    cmd;
    t_status status;

    rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rle_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/core/rle_dp.sv
// ----------------------------------------------------------------------------
// Run/literal encoder datapath
// Holds the literal store, the literal and run state, the current item, the
// output byte packer and the output register.
// ----------------------------------------------------------------------------
module rle_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rle_pkg::t_in_item  i_in_data,
    input  rle_pkg::t_cmd      i_cmd,
    output rle_pkg::t_status   o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rle_pkg::t_out_item o_out_data
);
    import rle_pkg::*;

    logic [7:0]        r_mem [MAX_PACKET];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [CNT_W-1:0]  r_left;
    logic [7:0]        r_byte;
    logic              r_fin;
    logic [CNT_W-1:0]  r_lit_cnt;
    logic [CNT_W-1:0]  r_run_cnt;
    logic [7:0]        r_run_val;
    logic [WORD_W-1:0] r_acc;
    logic [BC_W-1:0]   r_acc_cnt;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CNT_W-1:0]  n_lit_cnt;
    logic [CNT_W-1:0]  n_run_cnt;
    logic [7:0]        n_run_val;
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic [7:0]        put_byte;
    logic              acc_full;
    logic              slot_free;
    logic              push;
    t_out_item         push_word;

    assign slot_free = !r_out_valid || i_out_ready;
    assign acc_full  = (r_acc_cnt == BC_W'(LANE_BYTES));
    assign last_addr = (r_lit_cnt == '0) ? '0 : ADDR_W'(r_lit_cnt - 1'b1);

    always_comb begin
        case (i_cmd.rd_op)
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = r_rd_idx;
            default:  rd_addr = last_addr;
        endcase
    end

    assign wr_en   = (i_cmd.lit_op inside {LIT_ADD_BYTE, LIT_ADD_RUN});
    assign wr_data = (i_cmd.lit_op == LIT_ADD_RUN) ? r_run_val : r_byte;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ADDR_W'(r_lit_cnt)] <= wr_data;
        end
        if (i_cmd.rd_op != RD_HOLD) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.rd_op)
            RD_FIRST: begin
                r_rd_idx <= ADDR_W'(1);
                r_left   <= r_lit_cnt;
            end
            RD_NEXT: begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_left   <= r_left - 1'b1;
            end
            default: begin
                r_rd_idx <= r_rd_idx;
                r_left   <= r_left;
            end
        endcase
        if (i_cmd.load) begin
            r_byte <= i_in_data.data_byte;
            r_fin  <= i_in_data.is_final;
        end
    end

    always_comb begin
        case (i_cmd.lit_op)
            LIT_ADD_BYTE, LIT_ADD_RUN: n_lit_cnt = r_lit_cnt + 1'b1;
            LIT_DEC:                   n_lit_cnt = r_lit_cnt - 1'b1;
            LIT_CLEAR:                 n_lit_cnt = '0;
            default:                   n_lit_cnt = r_lit_cnt;
        endcase
    end

    always_comb begin
        n_run_cnt = r_run_cnt;
        n_run_val = r_run_val;
        case (i_cmd.run_op)
            RUN_NEW: begin
                n_run_cnt = CNT_W'(1);
                n_run_val = r_byte;
            end
            RUN_INC:    n_run_cnt = r_run_cnt + 1'b1;
            RUN_DEC:    n_run_cnt = r_run_cnt - 1'b1;
            RUN_START2: begin
                n_run_cnt = CNT_W'(2);
                n_run_val = r_byte;
            end
            RUN_ZERO:   n_run_cnt = '0;
            RUN_CLEAR: begin
                n_run_cnt = '0;
                n_run_val = '0;
            end
            default: begin
                n_run_cnt = r_run_cnt;
                n_run_val = r_run_val;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.put)
            PUT_LIT_HDR: put_byte = LIT_FLAG | (8'(r_lit_cnt) & LEN_MASK);
            PUT_RUN_HDR: put_byte = RUN_FLAG | (8'(r_run_cnt) & LEN_MASK);
            PUT_RUN_VAL: put_byte = r_run_val;
            PUT_MEM:     put_byte = r_rd_data;
            default:     put_byte = '0;
        endcase
    end

    always_comb begin
        push      = 1'b0;
        push_word = '{stream_end: 1'b0, last_for_item: 1'b0,
                      byte_count: BC_W'(LANE_BYTES), packed_bytes: r_acc};
        if (i_cmd.flush) begin
            push      = 1'b1;
            push_word = '{stream_end: r_fin, last_for_item: 1'b1,
                          byte_count: r_acc_cnt, packed_bytes: r_acc};
        end else if (i_cmd.put != PUT_NONE && acc_full) begin
            push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit_cnt   <= '0;
            r_run_cnt   <= '0;
            r_run_val   <= '0;
            r_acc       <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lit_cnt <= n_lit_cnt;
            r_run_cnt <= n_run_cnt;
            r_run_val <= n_run_val;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.flush) begin
                r_acc     <= '0;
                r_acc_cnt <= '0;
            end else if (i_cmd.put != PUT_NONE) begin
                if (acc_full) begin
                    r_acc     <= WORD_W'(put_byte);
                    r_acc_cnt <= BC_W'(1);
                end else begin
                    r_acc[8*r_acc_cnt[LANE_IDX_W-1:0] +: 8] <= put_byte;
                    r_acc_cnt <= r_acc_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= push_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status.item_fin     = r_fin;
        o_status.lit_zero     = (r_lit_cnt == '0);
        o_status.run_zero     = (r_run_cnt == '0);
        o_status.run_one      = (r_run_cnt == CNT_W'(1));
        o_status.run_gt2      = (r_run_cnt > CNT_W'(2));
        o_status.rv_eq_b      = (r_run_val == r_byte);
        o_status.last_eq_b    = (r_rd_data == r_byte);
        o_status.run_inc_full = ((CNT_W+1)'(r_run_cnt) + 1'b1) >= (CNT_W+1)'(MAX_PACKET);
        o_status.lit_inc_full = ((CNT_W+1)'(r_lit_cnt) + 1'b1) >= (CNT_W+1)'(MAX_PACKET);
        o_status.left_one     = (r_left == CNT_W'(1));
        o_status.put_ready    = !acc_full || slot_free;
        o_status.slot_free    = slot_free;
        o_status.acc_empty    = (r_acc_cnt == '0);
    end

    // A word is never pushed over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> slot_free)
        else $error("output word pushed while the output register is held");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_cnt <= BC_W'(LANE_BYTES))
        else $error("packer holds more bytes than a word");

    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_lit_cnt < CNT_W'(MAX_PACKET)))
        else $error("literal written beyond the store");

    a_partial_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_for_item) |-> (r_out.byte_count == BC_W'(LANE_BYTES)))
        else $error("partial word that does not end its item");

endmodule

// File: rtl/core/rle_ctrl.sv
// ----------------------------------------------------------------------------
// Run/literal encoder controller
// Sequences each item: decision, literal additions, packet emission, the
// end-of-stream flush and the final partial word.
// ----------------------------------------------------------------------------
module rle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rle_pkg::t_status i_status,
    output rle_pkg::t_cmd    o_cmd
);
    import rle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ADD_RUN,
        S_ADD_BYTE,
        S_LIT_HDR,
        S_LIT_DATA,
        S_RUN_HDR,
        S_RUN_VAL,
        S_FINAL,
        S_FLUSH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_then_run;
    logic    n_then_run;
    t_run_op r_run_after;
    t_run_op n_run_after;
    t_cmd    cmd;

    always_comb begin
        n_state     = r_state;
        n_then_run  = r_then_run;
        n_run_after = r_run_after;
        cmd         = '{load: 1'b0, run_op: RUN_HOLD, lit_op: LIT_HOLD,
                        rd_op: RD_HOLD, put: PUT_NONE, flush: 1'b0};
        case (r_state)
            S_IDLE: begin
                cmd.rd_op = RD_LAST;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_status.item_fin ? S_FINAL : S_IDLE;
                if (i_status.lit_zero) begin
                    if (i_status.run_zero) begin
                        cmd.run_op = RUN_NEW;
                    end else if (i_status.rv_eq_b) begin
                        cmd.run_op = RUN_INC;
                        if (i_status.run_inc_full) begin
                            n_state     = S_RUN_HDR;
                            n_run_after = RUN_ZERO;
                        end
                    end else if (i_status.run_gt2) begin
                        n_state     = S_RUN_HDR;
                        n_run_after = RUN_NEW;
                    end else begin
                        n_state = S_ADD_RUN;
                    end
                end else if (!i_status.run_zero) begin
                    if (i_status.rv_eq_b) begin
                        cmd.run_op = RUN_INC;
                        if (i_status.run_inc_full) begin
                            n_state     = S_LIT_HDR;
                            n_then_run  = 1'b1;
                            n_run_after = RUN_ZERO;
                        end
                    end else begin
                        n_state     = S_LIT_HDR;
                        n_then_run  = 1'b1;
                        n_run_after = RUN_NEW;
                    end
                end else if (i_status.last_eq_b) begin
                    cmd.run_op = RUN_START2;
                    cmd.lit_op = LIT_DEC;
                end else begin
                    cmd.lit_op = LIT_ADD_BYTE;
                    if (i_status.lit_inc_full) begin
                        n_state    = S_LIT_HDR;
                        n_then_run = 1'b0;
                    end
                end
            end
            S_ADD_RUN: begin
                cmd.lit_op = LIT_ADD_RUN;
                cmd.run_op = RUN_DEC;
                if (i_status.run_one) begin
                    n_state = S_ADD_BYTE;
                end
            end
            S_ADD_BYTE: begin
                cmd.lit_op = LIT_ADD_BYTE;
                if (i_status.lit_inc_full) begin
                    n_state    = S_LIT_HDR;
                    n_then_run = 1'b0;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_LIT_HDR: begin
                if (i_status.put_ready) begin
                    cmd.put   = PUT_LIT_HDR;
                    cmd.rd_op = RD_FIRST;
                    n_state   = S_LIT_DATA;
                end
            end
            S_LIT_DATA: begin
                if (i_status.put_ready) begin
                    cmd.put = PUT_MEM;
                    if (i_status.left_one) begin
                        cmd.lit_op = LIT_CLEAR;
                        n_state    = r_then_run ? S_RUN_HDR : S_FINAL;
                    end else begin
                        cmd.rd_op = RD_NEXT;
                    end
                end
            end
            S_RUN_HDR: begin
                if (i_status.put_ready) begin
                    cmd.put = PUT_RUN_HDR;
                    n_state = S_RUN_VAL;
                end
            end
            S_RUN_VAL: begin
                if (i_status.put_ready) begin
                    cmd.put    = PUT_RUN_VAL;
                    cmd.run_op = r_run_after;
                    n_state    = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state = S_FLUSH;
                if (i_status.item_fin) begin
                    if (!i_status.lit_zero) begin
                        n_state     = S_LIT_HDR;
                        n_then_run  = !i_status.run_zero;
                        n_run_after = RUN_ZERO;
                    end else if (!i_status.run_zero) begin
                        n_state     = S_RUN_HDR;
                        n_run_after = RUN_ZERO;
                    end else begin
                        cmd.run_op = RUN_CLEAR;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.acc_empty) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    cmd.flush = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_then_run  <= 1'b0;
            r_run_after <= RUN_ZERO;
        end else begin
            r_state     <= n_state;
            r_then_run  <= n_then_run;
            r_run_after <= n_run_after;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE))
        else $error("accepted item not followed by its decision");

    a_put_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.put != PUT_NONE) |-> i_status.put_ready)
        else $error("byte issued while the packer cannot take it");

    a_flush_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |-> (i_status.slot_free && !i_status.acc_empty))
        else $error("word flush without room or without bytes");

endmodule
